// ===== hdl/jagged_row_to_dense_row_mapper_core_macros.svh =====
// Assertion macros for the jagged row mapper.
// Used by the top level.
`ifndef JAGGED_ROW_TO_DENSE_ROW_MAPPER_CORE_MACROS_SVH
`define JAGGED_ROW_TO_DENSE_ROW_MAPPER_CORE_MACROS_SVH
`define JRD_ASSERT_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define JRD_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

// ===== hdl/jrd_pkg.sv =====
// Package for the jagged row mapper: opcodes and register indexes.
// No dependencies.
`timescale 1ns / 1ps
package jrd_pkg;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MAP  = 1'b1;
  localparam logic [2:0] REG_LEVEL_COUNT = 3'd0;
  localparam logic [2:0] REG_MAX_LEN_0 = 3'd1;
  localparam logic [2:0] REG_MAX_LEN_4 = 3'd5;
  localparam int CFG_IDX_W = 3;
  localparam int VALUE_W = 24;
  localparam int DENSE_W = 48;
  localparam int LEN_W = 16;
endpackage

// ===== hdl/jrd_if.sv =====
// Valid/ready channel interfaces for input, output and configuration.
// Depends on jrd_pkg.
`timescale 1ns / 1ps
interface jrd_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic [2:0] level;
  logic [9:0] entry_index;
  logic [23:0] entry_value;
  logic [23:0] jagged_row;
  modport source (output valid, opcode, level, entry_index, entry_value, jagged_row,
                  input ready);
  modport sink (input valid, opcode, level, entry_index, entry_value, jagged_row,
                output ready);
endinterface

interface jrd_out_if;
  logic valid;
  logic ready;
  logic valid_res;
  logic [47:0] dense_row;
  modport source (output valid, valid_res, dense_row, input ready);
  modport sink (input valid, valid_res, dense_row, output ready);
endinterface

interface jrd_cfg_if;
  logic valid;
  logic ready;
  logic [jrd_pkg::CFG_IDX_W-1:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/jagged_row_to_dense_row_mapper_core.sv =====
// Jagged row to dense row mapper. A load writes one table entry. A map runs, per
// level, a binary search on the single offsets memory port (each probe passes
// S_PROBE, S_WAIT and S_CMP, read data registered, plus setup and the final read),
// then S_MAC0 and S_MAC1 per level on the shared multiply-add unit and S_OUT to
// present the result. The result is held in an output register; the block takes
// no new item until it has been taken. No clearing pass is needed.
`timescale 1ns / 1ps
`include "jagged_row_to_dense_row_mapper_core_macros.svh"
module jagged_row_to_dense_row_mapper_core #(
  parameter int MAX_LEVELS = 5,
  parameter int TABLE_DEPTH = 1024,
  parameter int ROW_BITS = 24
) (
  input logic clk,
  input logic rst,
  jrd_in_if.sink in,
  jrd_out_if.source out,
  jrd_cfg_if.sink cfg
);
  localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = IW + 1;
  localparam int AW = $clog2(MAX_LEVELS * TABLE_DEPTH);
  localparam int DW = jrd_pkg::DENSE_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LVL, S_PROBE, S_WAIT, S_CMP, S_FIN_RD, S_FIN_WAIT, S_FIN,
    S_MAC0, S_MAC1, S_OUT
  } state_t;

  state_t state;

  logic [23:0] mem [MAX_LEVELS*TABLE_DEPTH];
  logic [23:0] rdata;
  logic [AW-1:0] raddr;
  logic [NW-1:0] tlen [MAX_LEVELS];
  logic [2:0] level_count;
  logic [15:0] max_len [MAX_LEVELS];
  logic [15:0] coords [MAX_LEVELS];

  logic [LW-1:0] lvl;
  logic [LW:0] n_lv;
  logic [23:0] target;
  logic signed [NW+1:0] lo, hi, mid;
  logic [DW-1:0] acc;
  logic [LW:0] k;
  logic res_ok;
  logic [DW-1:0] res_row;

  logic [DW-1:0] mac_res;
  logic mac_ovf;
  logic [15:0] mac_len, mac_coord;

  function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] l, input logic [NW+1:0] i);
    logic [AW+LW:0] a;
    a = (AW+LW+1)'(l) * (AW+LW+1)'(TABLE_DEPTH) + (AW+LW+1)'(i[IW-1:0]);
    return a[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (in.valid && in.ready && in.opcode == jrd_pkg::OP_LOAD &&
        32'(in.level) < MAX_LEVELS && 32'(in.entry_index) < TABLE_DEPTH)
      mem[addr_of(in.level[LW-1:0], (NW+2)'(in.entry_index))] <= in.entry_value;
    rdata <= mem[raddr];
  end

  jrd_mac u_mac (.clk(clk), .acc(acc), .len(mac_len), .coord(mac_coord),
                 .res(mac_res), .ovf(mac_ovf));

  always_comb begin
    mac_len = '0;
    mac_coord = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (32'(k) == i) begin
        mac_len = max_len[i];
        mac_coord = coords[i];
      end
    end
  end

  assign cfg.ready = (state == S_IDLE) && !out.valid;
  assign in.ready = (state == S_IDLE) && !out.valid;
  assign out.valid_res = res_ok;
  assign out.dense_row = res_row;

  logic [NW-1:0] cur_len;
  logic [15:0] cur_max;
  logic [24:0] diff;
  always_comb begin
    cur_len = tlen[lvl];
    cur_max = max_len[lvl];
    diff = {1'b0, target} - {1'b0, rdata};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out.valid <= 1'b0;
      level_count <= 3'd1;
      for (int i = 0; i < MAX_LEVELS; i++) max_len[i] <= 16'd1;
      for (int i = 0; i < MAX_LEVELS; i++) tlen[i] <= '0;
    end else begin
      if (out.valid && out.ready) out.valid <= 1'b0;
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == jrd_pkg::REG_LEVEL_COUNT) level_count <= cfg.data[2:0];
        else if (cfg.index <= jrd_pkg::REG_MAX_LEN_4 &&
                 32'(cfg.index - jrd_pkg::REG_MAX_LEN_0) < MAX_LEVELS)
          max_len[LW'(cfg.index - jrd_pkg::REG_MAX_LEN_0)] <= cfg.data;
      end
      unique case (state)
        S_IDLE: begin
          if (in.valid && in.ready) begin
            if (in.opcode == jrd_pkg::OP_LOAD) begin
              if (32'(in.level) < MAX_LEVELS && 32'(in.entry_index) < TABLE_DEPTH)
                tlen[in.level[LW-1:0]] <= NW'(in.entry_index) + NW'(1);
            end else begin
              target <= in.jagged_row & 24'((25'd1 << ROW_BITS) - 25'd1);
              if (32'(level_count) > MAX_LEVELS) n_lv <= (LW+1)'(MAX_LEVELS);
              else n_lv <= (LW+1)'(level_count);
              if (level_count == 3'd0) begin
                acc <= '0;
                k <= '0;
                res_ok <= 1'b1;
                res_row <= '0;
                state <= S_OUT;
              end else begin
                if (32'(level_count) > MAX_LEVELS) lvl <= LW'(MAX_LEVELS - 1);
                else lvl <= LW'(level_count - 3'd1);
                state <= S_LVL;
              end
            end
          end
        end
        S_LVL: begin
          lo <= '0;
          hi <= (NW+2)'(cur_len) - (NW+2)'(1);
          state <= S_PROBE;
        end
        S_PROBE: begin
          if (lo <= hi) begin
            mid <= (lo + hi) >>> 1;
            raddr <= addr_of(lvl, (lo + hi) >>> 1);
            state <= S_WAIT;
          end else begin
            if (hi < 0 || hi >= (NW+2)'(cur_len) - (NW+2)'(1)) begin
              res_ok <= 1'b0;
              res_row <= '0;
              state <= S_OUT;
            end else begin
              raddr <= addr_of(lvl, hi);
              state <= S_FIN_RD;
            end
          end
        end
        S_WAIT: state <= S_CMP;
        S_CMP: begin
          if (rdata <= target) lo <= mid + 1;
          else hi <= mid - 1;
          state <= S_PROBE;
        end
        S_FIN_RD: state <= S_FIN_WAIT;
        S_FIN_WAIT: state <= S_FIN;
        S_FIN: begin
          if (diff[24] || diff[23:0] >= {8'd0, cur_max}) begin
            res_ok <= 1'b0;
            res_row <= '0;
            state <= S_OUT;
          end else begin
            coords[lvl] <= diff[15:0];
            target <= 24'(hi[NW-1:0]);
            if (lvl == '0) begin
              acc <= DW'(hi[NW-1:0]);
              k <= '0;
              state <= S_MAC0;
            end else begin
              lvl <= lvl - LW'(1);
              state <= S_LVL;
            end
          end
        end
        S_MAC0: begin
          if (k == n_lv) begin
            res_ok <= 1'b1;
            res_row <= acc;
            state <= S_OUT;
          end else state <= S_MAC1;
        end
        S_MAC1: begin
          if (mac_ovf) begin
            res_ok <= 1'b0;
            res_row <= '0;
            state <= S_OUT;
          end else begin
            acc <= mac_res;
            k <= k + (LW+1)'(1);
            state <= S_MAC0;
          end
        end
        S_OUT: begin
          out.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `JRD_ASSERT_IMPL(a_busy_no_ready, clk, rst, state != S_IDLE, !in.ready)
  `JRD_ASSERT_NEXT(a_out_from_out, clk, rst, state == S_OUT, out.valid)
  `JRD_ASSERT_IMPL(a_invalid_zero, clk, rst, out.valid && !out.valid_res, out.dense_row == '0)
endmodule

// ===== hdl/jrd_mac.sv =====
// Shared multiply-add unit: acc*len + coord with 48-bit overflow flag; products and coord are registered.
// Depends on jrd_pkg.
`timescale 1ns / 1ps
module jrd_mac (
  input  logic clk,
  input  logic [jrd_pkg::DENSE_W-1:0] acc,
  input  logic [jrd_pkg::LEN_W-1:0] len,
  input  logic [jrd_pkg::LEN_W-1:0] coord,
  output logic [jrd_pkg::DENSE_W-1:0] res,
  output logic ovf
);
  logic [39:0] lo_p;
  logic [39:0] hi_p;
  logic [jrd_pkg::LEN_W-1:0] coord_q;
  logic [65:0] sum;
  always_ff @(posedge clk) begin
    lo_p <= acc[23:0] * len;
    hi_p <= acc[47:24] * len;
    coord_q <= coord;
  end
  always_comb begin
    sum = {2'd0, hi_p, 24'd0} + {26'd0, lo_p} + {50'd0, coord_q};
    res = sum[47:0];
    ovf = |sum[65:48];
  end
endmodule

// ===== test/jagged_row_to_dense_row_mapper_core_tb.sv =====
// Testbench for jagged_row_to_dense_row_mapper_core: builds offsets tables, maps rows
// and checks each dense row against an in-bench predictor, with random stalls on both sides.
// Depends on jrd_pkg, the channel interfaces in jrd_if.sv and the core.
`timescale 1ns / 1ps
module jagged_row_to_dense_row_mapper_core_tb;

  localparam int N_LEVELS = 5;
  localparam int DEPTH = 1024;
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;
  localparam int IDLE_PAUSE = 300;

  typedef struct packed {
    logic ok;
    logic [jrd_pkg::DENSE_W-1:0] dense;
  } dense_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  jrd_in_if in_ch();
  jrd_out_if out_ch();
  jrd_cfg_if cfg_ch();

  jagged_row_to_dense_row_mapper_core uut (
    .clk(clk), .rst(rst), .in(in_ch), .out(out_ch), .cfg(cfg_ch)
  );

  logic [jrd_pkg::VALUE_W-1:0] offsets [N_LEVELS][DEPTH];
  bit written [N_LEVELS][DEPTH];
  int unsigned table_len [N_LEVELS];
  int unsigned level_cnt;
  int unsigned max_len [N_LEVELS];
  dense_result_t dense_expect[$];
  int errors = 0;
  bit no_gaps = 1'b0;

  function automatic dense_result_t predict_dense_row(logic [23:0] row);
    dense_result_t r;
    longint coords [N_LEVELS];
    longint target, outer, lo, hi, mid, len, pos, coord;
    longint unsigned acc;
    int n;
    r = '0;
    n = (level_cnt > N_LEVELS) ? N_LEVELS : level_cnt;
    target = longint'(row);
    outer = 0;
    foreach (coords[k]) coords[k] = 0;
    for (int i = n - 1; i >= 0; i--) begin
      len = table_len[i];
      lo = 0;
      hi = len - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (longint'(offsets[i][mid]) <= target) lo = mid + 1;
        else hi = mid - 1;
      end
      pos = hi;
      if (pos < 0 || pos >= len - 1) return r;
      coord = target - longint'(offsets[i][pos]);
      if (coord < 0 || coord >= longint'(max_len[i])) return r;
      coords[i] = coord;
      target = pos;
      if (i == 0) outer = pos;
    end
    acc = outer;
    for (int k = 0; k < n; k++) begin
      acc = acc * longint'(max_len[k]) + coords[k];
      if (acc > 64'hFFFF_FFFF_FFFF) return r;
    end
    r.ok = 1'b1;
    r.dense = acc[jrd_pkg::DENSE_W-1:0];
    return r;
  endfunction

  // a map may only run when every searched table is fully written
  function automatic bit tables_complete();
    int n;
    n = (level_cnt > N_LEVELS) ? N_LEVELS : level_cnt;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < table_len[i]; j++)
        if (!written[i][j]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic send_item(logic op, logic [2:0] lvl, logic [9:0] idx,
                           logic [23:0] value, logic [23:0] row);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.level <= lvl;
    in_ch.entry_index <= idx;
    in_ch.entry_value <= value;
    in_ch.jagged_row <= row;
    do @(posedge clk); while (!in_ch.ready);
    if (op == jrd_pkg::OP_MAP) begin
      dense_expect.push_back(predict_dense_row(row));
    end else if (lvl < N_LEVELS) begin
      offsets[lvl][idx] = value;
      written[lvl][idx] = 1'b1;
      table_len[lvl] = idx + 1;
    end
    @(negedge clk);
  endtask

  task automatic load_entry(int lvl, int idx, int value);
    send_item(jrd_pkg::OP_LOAD, lvl[2:0], idx[9:0], value[23:0], 24'($urandom()));
  endtask

  task automatic map_row(logic [23:0] row);
    if (tables_complete())
      send_item(jrd_pkg::OP_MAP, 3'($urandom()), 10'($urandom()), 24'($urandom()), row);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    in_ch.valid <= 1'b0;
    wait (dense_expect.size() == 0);
    repeat (IDLE_PAUSE) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == jrd_pkg::REG_LEVEL_COUNT) level_cnt = data[2:0];
    else if (idx <= jrd_pkg::REG_MAX_LEN_0 + N_LEVELS - 1)
      max_len[idx - jrd_pkg::REG_MAX_LEN_0] = data;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // build nested tables: level 0 holds batches, each deeper level the children
  task automatic build_tables(int max_step);
    int parents, off;
    parents = $urandom_range(1, 4);
    for (int lv = 0; lv < N_LEVELS; lv++) begin
      off = 0;
      for (int k = 0; k <= parents; k++) begin
        load_entry(lv, k, off);
        if (off < 12) off += $urandom_range(0, max_step);
      end
      parents = off;
    end
  endtask

  function automatic logic [23:0] pick_row();
    int inner;
    inner = (level_cnt == 0) ? 0 : ((level_cnt > N_LEVELS) ? N_LEVELS : level_cnt) - 1;
    if ($urandom_range(0, 9) == 0 || table_len[inner] == 0) return 24'($urandom());
    return 24'($urandom_range(0, offsets[inner][table_len[inner] - 1] + 2));
  endfunction

  always begin
    int stall;
    stall = no_gaps ? 0 : $urandom_range(0, 6);
    if (stall > 0) begin
      out_ch.ready <= 1'b0;
      repeat (stall) @(negedge clk);
    end
    out_ch.ready <= 1'b1;
    do @(posedge clk); while (!(out_ch.valid && !rst));
    if (dense_expect.size() == 0) begin
      $display("%0t: unexpected transaction valid_res=%0b dense_row=%0h",
               $time, out_ch.valid_res, out_ch.dense_row);
      errors++;
    end else begin
      dense_result_t e;
      e = dense_expect.pop_front();
      if (out_ch.valid_res !== e.ok) begin
        $display("%0t: valid_res expected %0b actual %0b", $time, e.ok, out_ch.valid_res);
        errors++;
      end
      if (out_ch.dense_row !== e.dense) begin
        $display("%0t: dense_row expected %0h actual %0h", $time, e.dense, out_ch.dense_row);
        errors++;
      end
    end
    @(negedge clk);
  end

  task automatic test_reset_defaults();
    map_row(24'd0);
    map_row(24'd5);
  endtask

  task automatic test_directed();
    write_reg(jrd_pkg::REG_LEVEL_COUNT, 16'd2);
    write_reg(jrd_pkg::REG_MAX_LEN_0, 16'd3);
    write_reg(jrd_pkg::REG_MAX_LEN_0 + 3'd1, 16'd4);
    load_entry(0, 0, 0); load_entry(0, 1, 2); load_entry(0, 2, 3);
    load_entry(1, 0, 0); load_entry(1, 1, 3); load_entry(1, 2, 3); load_entry(1, 3, 7);
    load_entry(3, 0, 24'hFFFFFF);
    send_item(jrd_pkg::OP_LOAD, 3'd7, 10'd0, 24'h123456, 24'd0);
    send_item(jrd_pkg::OP_LOAD, 3'd5, 10'd1, 24'h0, 24'd0);
    for (int r = 0; r <= 8; r++) map_row(r[23:0]);
    map_row(24'hFFFFFF);
    write_reg(jrd_pkg::REG_LEVEL_COUNT, 16'd0);
    map_row(24'd3);
    write_reg(jrd_pkg::REG_LEVEL_COUNT, 16'd7);
    map_row(24'd1);
    write_reg(REG_SPARE_6, 16'hFFFF);
    write_reg(REG_SPARE_7, 16'h5A5A);
    write_reg(jrd_pkg::REG_LEVEL_COUNT, 16'd2);
    load_entry(4, 1023, 24'hABCDEF);
    map_row(24'd2);
  endtask

  task automatic test_overflow();
    write_reg(jrd_pkg::REG_LEVEL_COUNT, 16'd5);
    for (int i = 0; i < N_LEVELS; i++) write_reg(jrd_pkg::REG_MAX_LEN_0 + i[2:0], 16'hFFFF);
    build_tables(3);
    for (int k = 0; k < 30; k++) map_row(pick_row());
  endtask

  task automatic test_random();
    int lv, idx;
    for (int phase = 0; phase < 9; phase++) begin
      no_gaps = (phase % 3 == 2);
      write_reg(jrd_pkg::REG_LEVEL_COUNT, 16'($urandom_range(0, 7)));
      for (int i = 0; i < N_LEVELS; i++) begin
        case ($urandom_range(0, 9))
          0: write_reg(jrd_pkg::REG_MAX_LEN_0 + i[2:0], 16'd0);
          1: write_reg(jrd_pkg::REG_MAX_LEN_0 + i[2:0], 16'hFFFF);
          2: write_reg(jrd_pkg::REG_MAX_LEN_0 + i[2:0], 16'($urandom()));
          default: write_reg(jrd_pkg::REG_MAX_LEN_0 + i[2:0], 16'($urandom_range(1, 4)));
        endcase
      end
      build_tables($urandom_range(1, 5));
      for (int k = 0; k < 70; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          lv = $urandom_range(0, 7);
          if (lv >= N_LEVELS) begin
            send_item(jrd_pkg::OP_LOAD, lv[2:0], 10'($urandom()), 24'($urandom()),
                      24'($urandom()));
          end else if (table_len[lv] > 0) begin
            idx = $urandom_range(0, table_len[lv] - 1);
            load_entry(lv, idx, $urandom());
          end
        end else begin
          map_row(pick_row());
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = jrd_pkg::OP_LOAD;
    in_ch.level = '0;
    in_ch.entry_index = '0;
    in_ch.entry_value = '0;
    in_ch.jagged_row = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    level_cnt = 1;
    foreach (max_len[i]) max_len[i] = 1;
    foreach (table_len[i]) table_len[i] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_directed();
    test_overflow();
    test_random();
    in_ch.valid <= 1'b0;
    wait (dense_expect.size() == 0);
    repeat (IDLE_PAUSE) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
